FILE: rtl/zpfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_pkg: shared types and constants
// Image size, depth store geometry, controller and shader state encodings,
// configuration register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package zpfs_pkg;

	// Image dimensions must be powers of two; the depth address is {column, row}.
	localparam int IMG_WIDTH     = 512;
	localparam int IMG_HEIGHT    = 512;
	localparam int COL_W         = $clog2(IMG_WIDTH);
	localparam int ROW_W         = $clog2(IMG_HEIGHT);
	localparam int DEPTH_AW      = COL_W + ROW_W;
	localparam int DEPTH_ENTRIES = IMG_WIDTH * IMG_HEIGHT;

	localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
	localparam logic [9:0]         HEIGHT_RESET = 10'd512;

	localparam logic CMD_SHADE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Iterative unit sizes.
	localparam int SQRT_IN_W  = 34;
	localparam int SQRT_OUT_W = 17;
	localparam int DIV_W      = 30;

	typedef enum logic [2:0] {
		CFG_LIGHT_DIR  = 3'd0,
		CFG_LIGHT_COL  = 3'd1,
		CFG_AMBIENT    = 3'd2,
		CFG_EYE_POS    = 3'd3,
		CFG_SHADE_MODE = 3'd4,
		CFG_IMG_HEIGHT = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TEST,
		ST_SHADE,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [4:0] {
		SH_IDLE,
		SH_NSQ,
		SH_NSQRT,
		SH_NDIV,
		SH_DOT,
		SH_CSET,
		SH_REFL,
		SH_VSQ,
		SH_VSQRT,
		SH_VDIV,
		SH_VDOT,
		SH_VFIN,
		SH_POW,
		SH_FAC,
		SH_CH,
		SH_DONE
	} shd_state_t;

	typedef struct packed {
		logic [47:0] light_dir;
		logic [47:0] light_col;
		logic [47:0] amb_col;
		logic [47:0] eye_pos;
		logic        spec;
	} shd_cfg_t;

	// Element 0 is x, 1 is y, 2 is z.
	typedef struct packed {
		logic [2:0][15:0] normal;
		logic [2:0][15:0] world;
		logic [23:0]      base;
	} shd_frag_t;

	typedef struct packed {
		logic        done;
		logic [23:0] rgb;
	} shd_res_t;

endpackage

FILE: rtl/zpfs_frag_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_frag_if: fragment input channel
// Valid/ready channel carrying one fragment or one depth clear command.
// ----------------------------------------------------------------------------
interface zpfs_frag_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [8:0]         pixel_x;
	logic [8:0]         pixel_y;
	logic signed [15:0] frag_depth;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic [23:0]        base_rgb;
	logic signed [15:0] world_x;
	logic signed [15:0] world_y;
	logic signed [15:0] world_z;

	modport source (
		output valid, cmd, pixel_x, pixel_y, frag_depth, normal_x, normal_y, normal_z,
		output base_rgb, world_x, world_y, world_z,
		input  ready
	);
	modport sink (
		input  valid, cmd, pixel_x, pixel_y, frag_depth, normal_x, normal_y, normal_z,
		input  base_rgb, world_x, world_y, world_z,
		output ready
	);
endinterface

FILE: rtl/zpfs_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_pix_if: pixel result channel
// Valid/ready channel carrying one result per fragment or clear command.
// ----------------------------------------------------------------------------
interface zpfs_pix_if;
	logic        valid;
	logic        ready;
	logic        pixel_written;
	logic [8:0]  out_column;
	logic [9:0]  out_row;
	logic [23:0] out_rgb;

	modport source (
		output valid, pixel_written, out_column, out_row, out_rgb,
		input  ready
	);
	modport sink (
		input  valid, pixel_written, out_column, out_row, out_rgb,
		output ready
	);
endinterface

FILE: rtl/zbuffer_phong_fragment_shade.sv
`timescale 1ns / 1ps
// A clear command, a failed depth test or a passing fragment in plain mode goes from
// the depth test to the output register; lit mode first runs the lighting sequencer,
// and specular mode also waits on its square root and divider units.
// One fragment at a time; the next is taken after the last result is loaded for output.
// Reset: control registers clear at once; then a clearing pass writes the minimum depth
// into all 262144 entries, one per cycle, and no fragment is taken until it ends.
// ----------------------------------------------------------------------------
// zbuffer_phong_fragment_shade: depth-tested fragment shader
// Depth store controller with output register around the lighting sequencer.
// ----------------------------------------------------------------------------
module zbuffer_phong_fragment_shade (
	input  logic        clk,
	input  logic        arst_n,
	zpfs_frag_if.sink   frag,
	zpfs_pix_if.source  pix,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);
	import zpfs_pkg::*;

	// Configuration registers. Write them only while the block is idle; the block does not enforce it.
	logic [47:0] light_dir_q, light_col_q, amb_col_q, eye_pos_q;
	logic [1:0]  mode_q;
	logic [9:0]  height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_dir_q <= '0;
			light_col_q <= '0;
			amb_col_q   <= '0;
			eye_pos_q   <= '0;
			mode_q      <= '0;
			height_q    <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIGHT_DIR:  light_dir_q <= cfg_wdata;
				CFG_LIGHT_COL:  light_col_q <= cfg_wdata;
				CFG_AMBIENT:    amb_col_q   <= cfg_wdata;
				CFG_EYE_POS:    eye_pos_q   <= cfg_wdata;
				CFG_SHADE_MODE: mode_q      <= cfg_wdata[1:0];
				CFG_IMG_HEIGHT: height_q    <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	// Controller state. The block holds a single fragment from acceptance until
	// its result sits in the output register, so reads and writes of the depth
	// store never overlap and no forwarding is needed.
	ctl_state_t state_q, state_d;
	logic [DEPTH_AW-1:0] clr_cnt_q;

	logic                cmd_q;
	logic [8:0]          px_q, py_q;
	logic signed [15:0]  depth_q;
	logic [DEPTH_AW-1:0] addr_q;
	shd_frag_t           frag_q;

	logic                res_written_q, res_written_d;
	logic [23:0]         res_rgb_q, res_rgb_d;
	logic                res_load;
	logic                out_load;

	logic                pix_valid_q;
	logic                pix_written_q;
	logic [8:0]          pix_column_q;
	logic [9:0]          pix_row_q;
	logic [23:0]         pix_rgb_q;

	logic                accept;
	logic [COL_W-1:0]    in_col;
	logic [ROW_W-1:0]    in_row;
	logic [DEPTH_AW-1:0] in_addr;

	logic                mem_we;
	logic [DEPTH_AW-1:0] mem_waddr;
	logic signed [15:0]  mem_wdata;
	logic signed [15:0]  mem_rdata;

	logic                shd_start;
	shd_cfg_t            shd_cfg;
	shd_res_t            shd_res;
	logic                normal_nz;

	assign frag.ready = (state_q == ST_IDLE);
	assign accept     = frag.valid && frag.ready;

	// The depth entry is the column times the image height plus the row; both
	// image sizes are powers of two, so this is a concatenation.
	always_comb begin
		in_col  = COL_W'(frag.pixel_x % IMG_WIDTH);
		in_row  = ROW_W'(frag.pixel_y % IMG_HEIGHT);
		in_addr = {in_col, in_row};
	end

	assign normal_nz = (frag_q.normal[0] != '0) || (frag_q.normal[1] != '0) ||
			(frag_q.normal[2] != '0);

	always_comb begin
		state_d       = state_q;
		mem_we        = 1'b0;
		mem_waddr     = addr_q;
		mem_wdata     = DEPTH_MIN;
		shd_start     = 1'b0;
		res_load      = 1'b0;
		res_written_d = 1'b0;
		res_rgb_d     = '0;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (clr_cnt_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (frag.valid) state_d = ST_TEST;
			end
			ST_TEST: begin
				// The stored depth for this pixel arrives from the memory here.
				if (cmd_q == CMD_CLEAR) begin
					mem_we   = 1'b1;
					res_load = 1'b1;
					state_d  = ST_EMIT;
				end else if (depth_q > mem_rdata) begin
					mem_we    = 1'b1;
					mem_wdata = depth_q;
					if (mode_q[0] && normal_nz) begin
						shd_start = 1'b1;
						state_d   = ST_SHADE;
					end else begin
						res_load      = 1'b1;
						res_written_d = 1'b1;
						res_rgb_d     = frag_q.base;
						state_d       = ST_EMIT;
					end
				end else begin
					res_load = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_SHADE: begin
				if (shd_res.done) begin
					res_load      = 1'b1;
					res_written_d = 1'b1;
					res_rgb_d     = shd_res.rgb;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Wait only while the previous result still sits untaken.
				if (!pix_valid_q || pix.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (out_load) begin
				pix_valid_q <= 1'b1;
			end else if (pix.ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the accepted item, the pending result and the output.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q            <= frag.cmd;
			px_q             <= frag.pixel_x;
			py_q             <= frag.pixel_y;
			depth_q          <= frag.frag_depth;
			addr_q           <= in_addr;
			frag_q.normal[0] <= frag.normal_x;
			frag_q.normal[1] <= frag.normal_y;
			frag_q.normal[2] <= frag.normal_z;
			frag_q.world[0]  <= frag.world_x;
			frag_q.world[1]  <= frag.world_y;
			frag_q.world[2]  <= frag.world_z;
			frag_q.base      <= frag.base_rgb;
		end
		if (res_load) begin
			res_written_q <= res_written_d;
			res_rgb_q     <= res_rgb_d;
		end
		if (out_load) begin
			pix_written_q <= res_written_q;
			pix_column_q  <= res_written_q ? px_q : 9'd0;
			pix_row_q     <= res_written_q ? height_q - {1'b0, py_q} : 10'd0;
			pix_rgb_q     <= res_written_q ? res_rgb_q : 24'd0;
		end
	end

	assign pix.valid         = pix_valid_q;
	assign pix.pixel_written = pix_written_q;
	assign pix.out_column    = pix_column_q;
	assign pix.out_row       = pix_row_q;
	assign pix.out_rgb       = pix_rgb_q;

	zpfs_depth_mem u_depth_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (in_addr),
		.rdata (mem_rdata)
	);

	assign shd_cfg.light_dir = light_dir_q;
	assign shd_cfg.light_col = light_col_q;
	assign shd_cfg.amb_col   = amb_col_q;
	assign shd_cfg.eye_pos   = eye_pos_q;
	assign shd_cfg.spec      = mode_q[1];

	zpfs_shade u_shade (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (shd_start),
		.cfg    (shd_cfg),
		.frag   (frag_q),
		.res    (shd_res)
	);

	// The clearing pass must finish before any fragment touches the store.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !frag.ready)
		else $error("fragment accepted during the depth clearing pass");

	// Every accepted transaction goes straight to the depth test.
	a_accept_to_test: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_TEST))
		else $error("accepted transaction did not reach the depth test");

	// The sequencer reports a colour only for a fragment that is waiting for it.
	a_shade_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		shd_res.done |-> (state_q == ST_SHADE))
		else $error("lighting result without a waiting fragment");

	// The store is only written during clearing or the depth test.
	a_store_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_CLEAR) || (state_q == ST_TEST)))
		else $error("depth store written outside the clear pass or depth test");
endmodule

FILE: rtl/zpfs_depth_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_depth_mem: depth store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module zpfs_depth_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [zpfs_pkg::DEPTH_AW-1:0] waddr,
	input  logic signed [15:0]            wdata,
	input  logic                          re,
	input  logic [zpfs_pkg::DEPTH_AW-1:0] raddr,
	output logic signed [15:0]            rdata
);
	import zpfs_pkg::*;

	logic [15:0] mem_q [DEPTH_ENTRIES];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = signed'(rdata_q);
endmodule

FILE: rtl/zpfs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_sqrt: iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module zpfs_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [zpfs_pkg::SQRT_IN_W-1:0]  radicand,
	output logic                            done,
	output logic [zpfs_pkg::SQRT_OUT_W-1:0] root
);
	import zpfs_pkg::*;

	localparam int CNT_W = $clog2(SQRT_OUT_W + 1);
	localparam int REM_W = SQRT_OUT_W + 2;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SQRT_IN_W-1:0]  x_q;
	logic [REM_W-1:0]      rem_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [REM_W+1:0]      rem_sh;
	logic [REM_W+1:0]      trial;
	logic                  take;

	always_comb begin
		rem_sh = {rem_q, x_q[SQRT_IN_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[SQRT_OUT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

FILE: rtl/zpfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zpfs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [zpfs_pkg::DIV_W-1:0]   dividend,
	input  logic [zpfs_pkg::SQRT_OUT_W-1:0] divisor,
	output logic                         done,
	output logic [zpfs_pkg::DIV_W-1:0]   quotient
);
	import zpfs_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIV_W-1:0]      dvd_q;
	logic [SQRT_OUT_W-1:0] dsr_q;
	logic [SQRT_OUT_W-1:0] rem_q;
	logic [SQRT_OUT_W:0]   rem_sh;
	logic                  take;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_W-1]};
		take   = (rem_sh >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits shift in where the dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], take};
			rem_q <= take ? SQRT_OUT_W'(rem_sh - {1'b0, dsr_q}) : SQRT_OUT_W'(rem_sh);
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

FILE: rtl/zpfs_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_shade: lighting sequencer
// Computes the lit colour of one fragment at a time with a single shared multiplier,
// a square root unit and a divider, stepping through the three lanes in turn.
// ----------------------------------------------------------------------------
module zpfs_shade (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  zpfs_pkg::shd_cfg_t  cfg,
	input  zpfs_pkg::shd_frag_t frag,
	output zpfs_pkg::shd_res_t  res
);
	import zpfs_pkg::*;

	function automatic logic [15:0] lane16(input logic [47:0] r, input logic [1:0] k);
		logic [15:0] v;
		case (k)
			2'd0:    v = r[47:32];
			2'd1:    v = r[31:16];
			default: v = r[15:0];
		endcase
		return v;
	endfunction

	shd_state_t state_q, state_d;
	logic [1:0]         k_q;
	logic               wait_q;
	logic signed [47:0] acc_q;
	logic [16:0]        len_q;
	logic signed [15:0] nu_q [3];
	logic signed [21:0] r_q [3];
	logic [17:0]        c_q;
	logic [14:0]        w_q;
	logic [20:0]        fac_q;
	logic [23:0]        rgb_q;

	logic signed [15:0] n_k, l_k, e_k, wd_k;
	logic [15:0]        lt_k, amb_k;
	logic [7:0]         byte_k;
	logic signed [16:0] diff_k;
	logic signed [23:0] mul_a, mul_b;
	logic signed [47:0] prod, acc_nxt, negdot, tmag, absacc;
	logic [17:0]        rq;
	logic [15:0]        dmag;
	logic               dneg;
	logic               sqrt_start, sqrt_done, div_start, div_done;
	logic [16:0]        sqrt_root;
	logic [DIV_W-1:0]   div_q;
	logic [15:0]        qv;
	logic [31:0]        ch_sum;
	logic [33:0]        ashift;

	always_comb begin
		n_k    = signed'(frag.normal[k_q]);
		wd_k   = signed'(frag.world[k_q]);
		l_k    = signed'(lane16(cfg.light_dir, k_q));
		e_k    = signed'(lane16(cfg.eye_pos, k_q));
		lt_k   = lane16(cfg.light_col, k_q);
		amb_k  = lane16(cfg.amb_col, k_q);
		diff_k = {wd_k[15], wd_k} - {e_k[15], e_k};
		case (k_q)
			2'd0:    byte_k = frag.base[23:16];
			2'd1:    byte_k = frag.base[15:8];
			default: byte_k = frag.base[7:0];
		endcase
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			SH_NSQ: begin
				mul_a = 24'(n_k);
				mul_b = 24'(n_k);
			end
			SH_DOT: begin
				mul_a = 24'(nu_q[k_q]);
				mul_b = 24'(l_k);
			end
			SH_REFL: begin
				mul_a = -24'(nu_q[k_q]);
				mul_b = signed'(24'({c_q, 1'b0}));
			end
			SH_VSQ: begin
				mul_a = 24'(diff_k);
				mul_b = 24'(diff_k);
			end
			SH_VDOT: begin
				mul_a = 24'(nu_q[k_q]);
				mul_b = 24'(r_q[k_q]);
			end
			SH_POW: begin
				mul_a = signed'(24'(w_q));
				mul_b = signed'(24'(w_q));
			end
			SH_FAC: begin
				mul_a = signed'(24'(lt_k));
				mul_b = signed'(24'(c_q));
			end
			SH_CH: begin
				mul_a = signed'(24'(byte_k));
				mul_b = signed'(24'(fac_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod    = mul_a * mul_b;
		acc_nxt = ((k_q == 2'd0) ? 48'sd0 : acc_q) + prod;
	end

	// Derived values for the sequencer steps.
	always_comb begin
		negdot = -acc_q;
		tmag   = prod[47] ? -prod : prod;
		rq     = tmag[31:14];
		absacc = acc_q[47] ? -acc_q : acc_q;
		ashift = absacc[47:14];
		ch_sum = 32'({prod[28:0], 2'b00}) + 32'({w_q, 8'b0}) - 32'(w_q) + 32'd8192;
		if (state_q == SH_VDIV) begin
			dneg = diff_k[16];
			dmag = diff_k[16] ? 16'(-diff_k) : 16'(diff_k);
		end else begin
			dneg = n_k[15];
			dmag = n_k[15] ? 16'(-17'(n_k)) : 16'(n_k);
		end
		qv         = {1'b0, div_q[14:0]};
		sqrt_start = ((state_q == SH_NSQRT) || (state_q == SH_VSQRT)) && !wait_q;
		div_start  = ((state_q == SH_NDIV) || (state_q == SH_VDIV)) && !wait_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SH_IDLE:  if (start) state_d = cfg.spec ? SH_NSQ : SH_DOT;
			SH_NSQ:   if (k_q == 2'd2) state_d = SH_NSQRT;
			SH_NSQRT: if (sqrt_done) state_d = SH_NDIV;
			SH_NDIV:  if (div_done && k_q == 2'd2) state_d = SH_DOT;
			SH_DOT:   if (k_q == 2'd2) state_d = SH_CSET;
			SH_CSET:  state_d = (cfg.spec && !(acc_q > 0)) ? SH_REFL : SH_FAC;
			SH_REFL:  if (k_q == 2'd2) state_d = SH_VSQ;
			SH_VSQ:   if (k_q == 2'd2) state_d = (acc_nxt == 0) ? SH_FAC : SH_VSQRT;
			SH_VSQRT: if (sqrt_done) state_d = SH_VDIV;
			SH_VDIV:  if (div_done && k_q == 2'd2) state_d = SH_VDOT;
			SH_VDOT:  if (k_q == 2'd2) state_d = SH_VFIN;
			SH_VFIN:  state_d = SH_POW;
			SH_POW:   if (k_q == 2'd3) state_d = SH_FAC;
			SH_FAC:   state_d = SH_CH;
			SH_CH:    state_d = (k_q == 2'd2) ? SH_DONE : SH_FAC;
			SH_DONE:  state_d = SH_IDLE;
			default:  state_d = SH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SH_IDLE;
			k_q     <= '0;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sqrt_start || div_start) begin
				wait_q <= 1'b1;
			end else if (sqrt_done || div_done) begin
				wait_q <= 1'b0;
			end
			case (state_q)
				SH_NSQ, SH_DOT, SH_REFL, SH_VSQ, SH_VDOT, SH_CH: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				SH_NDIV, SH_VDIV: begin
					if (div_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				SH_POW:  k_q <= k_q + 2'd1;
				SH_FAC:  k_q <= k_q;
				default: k_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SH_IDLE: begin
				w_q <= '0;
				if (start && !cfg.spec) begin
					nu_q[0] <= signed'(frag.normal[0]);
					nu_q[1] <= signed'(frag.normal[1]);
					nu_q[2] <= signed'(frag.normal[2]);
				end
			end
			SH_NSQ, SH_DOT, SH_VSQ, SH_VDOT: acc_q <= acc_nxt;
			SH_NSQRT, SH_VSQRT: if (sqrt_done) len_q <= sqrt_root;
			SH_NDIV, SH_VDIV: begin
				if (div_done) nu_q[k_q] <= signed'(dneg ? 16'd0 - qv : qv);
			end
			SH_CSET: c_q <= (negdot > 0) ? negdot[31:14] : 18'd0;
			SH_REFL: begin
				r_q[k_q] <= 22'(l_k) - (prod[47] ? -signed'(22'(rq)) : signed'(22'(rq)));
			end
			SH_VFIN: w_q <= (ashift > 34'd16384) ? 15'd16384 : ashift[14:0];
			SH_POW:  w_q <= prod[28:14];
			SH_FAC:  fac_q <= 21'(amb_k) + 21'(prod[33:14]);
			SH_CH: begin
				case (k_q)
					2'd0:    rgb_q[23:16] <= (ch_sum[31:14] > 18'd255) ? 8'hFF : ch_sum[21:14];
					2'd1:    rgb_q[15:8]  <= (ch_sum[31:14] > 18'd255) ? 8'hFF : ch_sum[21:14];
					default: rgb_q[7:0]   <= (ch_sum[31:14] > 18'd255) ? 8'hFF : ch_sum[21:14];
				endcase
			end
			default: begin
			end
		endcase
	end

	zpfs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q[SQRT_IN_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	zpfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dmag, 14'b0}),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign res.done = (state_q == SH_DONE);
	assign res.rgb  = rgb_q;
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the depth-tested fragment shader
// Streams fragments and depth clears through the valid/ready channels, keeps a
// shadow depth store and shading calculation, and checks every pixel result in
// order while both channel ends idle at random and the settings change.
// ----------------------------------------------------------------------------
module tb_top;
	import zpfs_pkg::*;

	typedef longint vec3_t [3];

	typedef struct {
		logic               cmd;
		logic [8:0]         px;
		logic [8:0]         py;
		logic signed [15:0] depth;
		logic signed [15:0] nrm [3];
		logic [23:0]        base;
		logic signed [15:0] wpos [3];
	} frag_t;

	typedef struct packed {
		logic        written;
		logic [8:0]  column;
		logic [9:0]  row;
		logic [23:0] rgb;
	} pix_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_wdata;

	zpfs_frag_if frag ();
	zpfs_pix_if  pix ();

	zbuffer_phong_fragment_shade dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frag      (frag.sink),
		.pix       (pix.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the configuration and of the depth store.
	logic [47:0]        light_dir_q, light_col_q, ambient_q, eye_q;
	logic [1:0]         mode_q;
	logic [9:0]         height_q;
	logic signed [15:0] depth_mem [DEPTH_ENTRIES];

	frag_t fragment_q [$];
	pix_t  pixel_q [$];

	int  mismatches = 0;
	int  results_seen = 0;
	int  frags_sent = 0;
	int  lit_passes = 0;
	bit  no_idle = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Generous cap: the clearing pass plus every fragment at specular latency.
	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Integer square root, bit by bit, floor result.
	function automatic longint isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// Scales a vector to Q14 length; returns 0 for the zero vector.
	function automatic bit unit_vec(input vec3_t a, output vec3_t o);
		longint s, len;
		s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		o[0] = 0; o[1] = 0; o[2] = 0;
		if (s == 0) return 1'b0;
		len = isqrt(s);
		for (int k = 0; k < 3; k++) o[k] = (a[k] * 16384) / len;
		return 1'b1;
	endfunction

	function automatic longint dot(input vec3_t a, input vec3_t b);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	// Depth test, store update and shading for one accepted transaction.
	function automatic pix_t shade_fragment(frag_t f);
		pix_t res;
		logic [17:0] addr;
		vec3_t n, nu, l, refl, diff, v;
		longint negdot, c, w, d, s, a, byte_v, lt, fac, ch;
		logic [23:0] rgb;
		res = '0;
		addr = {f.px, f.py};
		if (f.cmd == CMD_CLEAR) begin
			depth_mem[addr] = DEPTH_MIN;
			return res;
		end
		if (f.depth <= depth_mem[addr]) return res;
		depth_mem[addr] = f.depth;
		for (int k = 0; k < 3; k++) begin
			n[k] = longint'(f.nrm[k]);
			l[k] = longint'($signed(light_dir_q[47 - 16 * k -: 16]));
		end
		rgb = f.base;
		if (mode_q[0] && (n[0] != 0 || n[1] != 0 || n[2] != 0)) begin
			lit_passes++;
			if (mode_q[1]) void'(unit_vec(n, nu));
			else nu = n;
			negdot = -dot(nu, l);
			c = (negdot > 0) ? (negdot >>> 14) : 0;
			w = 0;
			// Specular only for front-facing fragments with a nonzero view vector.
			if (mode_q[1] && negdot >= 0) begin
				d = negdot >>> 14;
				for (int k = 0; k < 3; k++) begin
					refl[k] = l[k] - ((-nu[k]) * 2 * d) / 16384;
					diff[k] = longint'(f.wpos[k]) -
						longint'($signed(eye_q[47 - 16 * k -: 16]));
				end
				if (unit_vec(diff, v)) begin
					s = -dot(v, refl) / 16384;
					a = (s < 0) ? -s : s;
					if (a > 16384) a = 16384;
					w = a;
					repeat (4) w = (w * w) >>> 14;
				end
			end
			for (int k = 0; k < 3; k++) begin
				byte_v = longint'(f.base[23 - 8 * k -: 8]);
				lt = longint'(light_col_q[47 - 16 * k -: 16]);
				fac = longint'(ambient_q[47 - 16 * k -: 16]) + ((lt * c) >>> 14);
				ch = (byte_v * fac * 4 + 255 * w + 8192) >>> 14;
				if (ch > 255) ch = 255;
				rgb[23 - 8 * k -: 8] = ch[7:0];
			end
		end
		res.written = 1'b1;
		res.column = f.px;
		res.row = height_q - {1'b0, f.py};
		res.rgb = rgb;
		return res;
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sender: presents the head of the queue, predicts on each accepted transaction.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag.valid <= 1'b0;
			frag.cmd <= CMD_SHADE;
			frag.pixel_x <= '0;
			frag.pixel_y <= '0;
			frag.frag_depth <= '0;
			frag.normal_x <= '0;
			frag.normal_y <= '0;
			frag.normal_z <= '0;
			frag.base_rgb <= '0;
			frag.world_x <= '0;
			frag.world_y <= '0;
			frag.world_z <= '0;
			send_gap = 0;
		end else begin
			if (frag.valid && frag.ready) begin
				pixel_q.push_back(shade_fragment(fragment_q[0]));
				void'(fragment_q.pop_front());
				frags_sent++;
				send_gap = pick_gap();
			end
			if (send_gap > 0) begin
				send_gap--;
				frag.valid <= 1'b0;
			end else if (fragment_q.size() > 0) begin
				frag.valid <= 1'b1;
				frag.cmd <= fragment_q[0].cmd;
				frag.pixel_x <= fragment_q[0].px;
				frag.pixel_y <= fragment_q[0].py;
				frag.frag_depth <= fragment_q[0].depth;
				frag.normal_x <= fragment_q[0].nrm[0];
				frag.normal_y <= fragment_q[0].nrm[1];
				frag.normal_z <= fragment_q[0].nrm[2];
				frag.base_rgb <= fragment_q[0].base;
				frag.world_x <= fragment_q[0].wpos[0];
				frag.world_y <= fragment_q[0].wpos[1];
				frag.world_z <= fragment_q[0].wpos[2];
			end else begin
				frag.valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result transaction against the oldest prediction.
	// Once, after a few hundred results, it holds ready low for a long stretch
	// so the shader backs up and stalls its fragment input.
	int  hold_cnt;
	bit  long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.ready <= 1'b0;
			hold_cnt = 0;
			long_hold_done = 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				results_seen++;
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result with nothing expected: w=%0b col=%0d row=%0d rgb=%06h",
							$realtime, pix.pixel_written, pix.out_column, pix.out_row, pix.out_rgb);
				end else begin
					if (pix.pixel_written !== pixel_q[0].written ||
					    pix.out_column !== pixel_q[0].column ||
					    pix.out_row !== pixel_q[0].row ||
					    pix.out_rgb !== pixel_q[0].rgb) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] pixel mismatch: exp w=%0b col=%0d row=%0d rgb=%06h, got w=%0b col=%0d row=%0d rgb=%06h",
								$realtime, pixel_q[0].written, pixel_q[0].column,
								pixel_q[0].row, pixel_q[0].rgb, pix.pixel_written,
								pix.out_column, pix.out_row, pix.out_rgb);
					end
					void'(pixel_q.pop_front());
				end
				if (results_seen == 300 && !long_hold_done) begin
					long_hold_done = 1'b1;
					hold_cnt = 600;
				end else if (hold_cnt == 0) begin
					hold_cnt = pick_gap();
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pix.ready <= 1'b0;
			end else begin
				pix.ready <= 1'b1;
			end
		end
	end

	// Register write, issued only when no fragment or result is in flight.
	task automatic write_reg(cfg_idx_t idx, logic [47:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_LIGHT_DIR:  light_dir_q = value;
			CFG_LIGHT_COL:  light_col_q = value;
			CFG_AMBIENT:    ambient_q = value;
			CFG_EYE_POS:    eye_q = value;
			CFG_SHADE_MODE: mode_q = value[1:0];
			CFG_IMG_HEIGHT: height_q = value[9:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] q14_comp();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// Light, colours, eye, shade mode and image height for one phase; sometimes all zero or all ones.
	task automatic set_scene(logic [1:0] mode, logic [9:0] height);
		int pick;
		logic [47:0] col, amb;
		pick = $urandom_range(0, 9);
		col = {4'h0, 12'($urandom), 4'h1, 12'($urandom), 4'h0, 12'($urandom)};
		amb = {4'h0, 10'h0, 2'($urandom), 4'h0, 10'h0, 2'($urandom), 4'h0, 12'($urandom)};
		if (pick == 0) begin
			col = '0;
			amb = '0;
		end else if (pick == 1) begin
			col = '1;
			amb = '1;
		end else if (pick == 2) begin
			col = {3{16'h1000}};
			amb = {$urandom, 16'($urandom)};
		end
		write_reg(CFG_LIGHT_DIR, (pick == 1) ? '1 : {q14_comp(), q14_comp(), q14_comp()});
		write_reg(CFG_LIGHT_COL, col);
		write_reg(CFG_AMBIENT, amb);
		write_reg(CFG_EYE_POS, (pick == 0) ? '0 : {$urandom, 16'($urandom)});
		write_reg(CFG_SHADE_MODE, 48'(mode));
		write_reg(CFG_IMG_HEIGHT, 48'(height));
	endtask

	function automatic frag_t make_frag(logic cmd, int x, int y, int z, int nx, int ny, int nz,
	                                    int rgb);
		frag_t f;
		f.cmd = cmd;
		f.px = x[8:0];
		f.py = y[8:0];
		f.depth = z[15:0];
		f.nrm[0] = nx[15:0];
		f.nrm[1] = ny[15:0];
		f.nrm[2] = nz[15:0];
		f.base = rgb[23:0];
		for (int k = 0; k < 3; k++) f.wpos[k] = 16'($urandom);
		return f;
	endfunction

	// Random fragment: a small hot set of pixels keeps the depth tests busy.
	function automatic frag_t random_frag();
		frag_t f;
		int r;
		f = make_frag(CMD_SHADE, $urandom, $urandom, $urandom, 0, 0, 0, $urandom);
		if ($urandom_range(0, 99) < 12) f.cmd = CMD_CLEAR;
		if ($urandom_range(0, 99) < 60) begin
			f.px = 9'($urandom_range(0, 5));
			f.py = 9'($urandom_range(0, 5));
		end
		r = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			if (r < 25) f.nrm[k] = 16'($urandom);
			else if (r < 90) f.nrm[k] = q14_comp();
			else if (r < 95) f.nrm[k] = 16'h0;
			else f.nrm[k] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
		end
		if ($urandom_range(0, 9) == 0) f.base = ($urandom_range(0, 1) != 0) ? 24'hffffff : 24'h0;
		return f;
	endfunction

	task automatic wait_drained();
		while (fragment_q.size() != 0 || pixel_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic run_phase(logic [1:0] mode, logic [9:0] height, int count, bit flat);
		set_scene(mode, height);
		no_idle = flat;
		repeat (count) fragment_q.push_back(random_frag());
		wait_drained();
		no_idle = 1'b0;
	endtask

	initial begin
		logic [47:0] eye_copy;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LIGHT_DIR;
		cfg_wdata = '0;
		light_dir_q = '0;
		light_col_q = '0;
		ambient_q = '0;
		eye_q = '0;
		mode_q = 2'd0;
		height_q = HEIGHT_RESET;
		for (int i = 0; i < DEPTH_ENTRIES; i++) depth_mem[i] = DEPTH_MIN;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lit-mode set: corner pixels, extreme depths and normals,
		// ties and losses in the depth test, clears, and a zero normal.
		set_scene(2'd1, 10'd512);
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 0, -32768, 0, 0, 16384, 'h123456));
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 0, -32767, 0, 0, -16384, 'hffffff));
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 0, -32767, 0, 0, -16384, 'hffffff));
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 0, 100, 0, 0, 0, 'habcdef));
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 0, 50, 0, 0, 16384, 'h0));
		fragment_q.push_back(make_frag(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 0, 50, -32768, -32768, -32768, 'hffffff));
		fragment_q.push_back(make_frag(CMD_SHADE, 511, 511, 32767, 32767, 32767, 32767, 'h0));
		fragment_q.push_back(make_frag(CMD_SHADE, 511, 511, 32767, 1, 1, 1, 'hffffff));
		fragment_q.push_back(make_frag(CMD_SHADE, 511, 0, 32767, -16384, 0, 0, 'h800080));
		fragment_q.push_back(make_frag(CMD_SHADE, 0, 511, 1, 0, 16384, 0, 'h7f7f7f));
		fragment_q.push_back(make_frag(CMD_CLEAR, 511, 511, 0, 0, 0, 0, 0));
		fragment_q.push_back(make_frag(CMD_SHADE, 511, 511, -32767, 0, -16384, 0, 'h010203));
		fragment_q.push_back(make_frag(CMD_CLEAR, 300, 200, 0, 0, 0, 0, 0));
		wait_drained();
		run_phase(2'd1, 10'd512, 200, 1'b0);

		// Specular: world equal to eye, then front- and back-facing fragments.
		set_scene(2'd3, 10'd512);
		eye_copy = eye_q;
		for (int i = 0; i < 4; i++) begin
			frag_t f;
			f = make_frag(CMD_SHADE, 400 + i, 9, 1000, 0, 0, 16384 - 32768 * (i % 2), 'hc08040);
			if (i == 0)
				for (int k = 0; k < 3; k++) f.wpos[k] = eye_copy[47 - 16 * k -: 16];
			fragment_q.push_back(f);
		end
		wait_drained();
		run_phase(2'd3, 10'd512, 90, 1'b0);

		run_phase(2'd0, 10'd1, 200, 1'b0);
		run_phase(2'd2, 10'd0, 150, 1'b0);
		run_phase(2'd1, 10'd1023, 250, 1'b1);
		run_phase(2'd1, 10'($urandom_range(1, 512)), 250, 1'b0);
		run_phase(2'd3, 10'($urandom_range(1, 1023)), 80, 1'b0);
		run_phase(2'd0, 10'd512, 300, 1'b0);

		repeat (300) @(posedge clk);
		$display("Covered %0d fragment and clear transactions, %0d results, %0d shaded by lighting,",
			frags_sent, results_seen, lit_passes);
		$display("across all four shade modes and image heights 0, 1, 512 and 1023.");
		if (mismatches == 0 && pixel_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
